// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the scorer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bhfs_pkg.sv -----
`timescale 1ns / 1ps

package bhfs_pkg;

  localparam int FP_DEPTH  = 32;
  localparam int EXP_DEPTH = 24;

  localparam int FP_AW  = (FP_DEPTH > 1) ? $clog2(FP_DEPTH) : 1;
  localparam int EXP_AW = (EXP_DEPTH > 1) ? $clog2(EXP_DEPTH) : 1;

  // field widths fixed by the interface
  localparam int HDR_W   = 24;
  localparam int OP_W    = 2;
  localparam int LEN_W   = 4;
  localparam int PCT_W   = 7;
  localparam int CNT_W   = 6;
  localparam int FILL_W  = 5;
  localparam int SCAN_W  = (CNT_W > FILL_W) ? CNT_W : FILL_W;
  localparam int PROD_W  = 12;
  localparam int STEP_W  = $clog2(PCT_W);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam int PCT_SCALE     = 100;
  localparam int MIN_FRAME_LEN = 3;
  localparam int THRESH_RESET  = 50;
  localparam int QUOT_MSB      = PCT_W - 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_OBSERVE = 2'd1,
    OP_EXPECT  = 2'd2,
    OP_FINISH  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPT_IN    = 1'd1;

  typedef struct packed {
    logic              go;
    logic [FILL_W-1:0] hits;
    logic [FILL_W-1:0] fill;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/bhfs_div.sv -----
`timescale 1ns / 1ps

// floor(hits*100/fill), one quotient bit per cycle, zero for an empty list
module bhfs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bhfs_pkg::div_req_t req,
  output bhfs_pkg::div_rsp_t rsp
);

  logic                                run_r;
  logic                                done_r;
  logic [bhfs_pkg::STEP_W-1:0]         step_r;
  logic [bhfs_pkg::PROD_W-1:0]         rem_r;
  logic [bhfs_pkg::FILL_W-1:0]         den_r;
  logic [bhfs_pkg::PCT_W-1:0]          q_r;
  logic [bhfs_pkg::PROD_W-1:0]         trial;

  assign trial = bhfs_pkg::PROD_W'(den_r) << step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r  <= 1'b1;
        step_r <= bhfs_pkg::STEP_W'(bhfs_pkg::QUOT_MSB);
        rem_r  <= bhfs_pkg::PROD_W'(req.hits) * bhfs_pkg::PROD_W'(bhfs_pkg::PCT_SCALE);
        den_r  <= req.fill;
        q_r    <= '0;
      end else if (run_r) begin
        if (rem_r >= trial) begin
          rem_r     <= rem_r - trial;
          q_r[step_r] <= 1'b1;
        end
        if (step_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.quot = (den_r == '0) ? '0 : q_r;
  end

endmodule

// ----- rtl/bus_header_fingerprint_scorer_unit.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Header fingerprint scorer. An item is taken when start is high and busy is low. Clear, an
// observe with bad CRC or length below 3, and an expect on a full list are handled without
// leaving idle. Other observe and expect items scan both memories one entry per cycle for a
// duplicate and a cross hit before the write.
// A finish runs the one-bit-per-cycle percentage divider; its result is shown on the out_
// ports with out_valid high for exactly one cycle and cannot be held off. The hit count is
// kept as headers arrive, so a finish does not rescan the memories.
module bus_header_fingerprint_scorer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bhfs_pkg::OP_W-1:0]         in_operation,
  input  logic [bhfs_pkg::HDR_W-1:0]        in_header,
  input  logic                              in_crc_ok,
  input  logic [bhfs_pkg::LEN_W-1:0]        in_frame_len,
  output logic                              out_valid,
  output logic [bhfs_pkg::PCT_W-1:0]        out_score_pct,
  output logic                              out_selected,
  output logic                              out_tx_allowed,
  output logic [bhfs_pkg::CNT_W-1:0]        out_distinct_seen,
  output logic [bhfs_pkg::FILL_W-1:0]       out_expected_count,
  input  logic                              cfg_we,
  input  logic [bhfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bhfs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_DIV} state_t;

  state_t                          state_r, state_nxt;
  logic [bhfs_pkg::CNT_W-1:0]      seen_count_r, seen_count_nxt;
  logic [bhfs_pkg::FILL_W-1:0]     exp_fill_r, exp_fill_nxt;
  logic [bhfs_pkg::FILL_W-1:0]     hits_r, hits_nxt;
  logic [bhfs_pkg::HDR_W-1:0]      hdr_r, hdr_nxt;
  bhfs_pkg::op_t                   op_r, op_nxt;
  logic [bhfs_pkg::SCAN_W-1:0]     idx_r, idx_nxt;
  logic [bhfs_pkg::SCAN_W-1:0]     scan_len_r, scan_len_nxt;
  logic                            sv_r, sv_nxt;
  logic                            ev_r, ev_nxt;
  logic                            in_seen_r, in_seen_nxt;
  logic                            in_exp_r, in_exp_nxt;
  logic [bhfs_pkg::PCT_W-1:0]      thresh_r;
  logic                            opt_in_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [bhfs_pkg::PCT_W-1:0]      out_conf_r, out_conf_nxt;
  logic                            out_sel_r, out_sel_nxt;
  logic                            out_tx_r, out_tx_nxt;
  logic [bhfs_pkg::CNT_W-1:0]      out_seen_r, out_seen_nxt;
  logic [bhfs_pkg::FILL_W-1:0]     out_exp_r, out_exp_nxt;

  logic                            seen_we;
  logic                            exp_we;
  logic                            issue;
  logic [bhfs_pkg::SCAN_W-1:0]     fill_ext;
  logic                            sel;

  logic [bhfs_pkg::HDR_W-1:0]      seen_mem [bhfs_pkg::FP_DEPTH];
  logic [bhfs_pkg::HDR_W-1:0]      exp_mem  [bhfs_pkg::EXP_DEPTH];
  logic [bhfs_pkg::HDR_W-1:0]      seen_q_r;
  logic [bhfs_pkg::HDR_W-1:0]      exp_q_r;

  bhfs_pkg::div_req_t              div_req;
  bhfs_pkg::div_rsp_t              div_rsp;

  bhfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign fill_ext     = bhfs_pkg::SCAN_W'(exp_fill_r);
  assign issue        = (idx_r < scan_len_r);
  assign sel          = (div_rsp.quot != '0) && (div_rsp.quot >= thresh_r);

  always_comb begin
    state_nxt      = state_r;
    seen_count_nxt = seen_count_r;
    exp_fill_nxt   = exp_fill_r;
    hits_nxt       = hits_r;
    hdr_nxt        = hdr_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    scan_len_nxt   = scan_len_r;
    sv_nxt         = 1'b0;
    ev_nxt         = 1'b0;
    in_seen_nxt    = in_seen_r;
    in_exp_nxt     = in_exp_r;
    out_valid_nxt  = 1'b0;
    out_conf_nxt   = out_conf_r;
    out_sel_nxt    = out_sel_r;
    out_tx_nxt     = out_tx_r;
    out_seen_nxt   = out_seen_r;
    out_exp_nxt    = out_exp_r;
    seen_we        = 1'b0;
    exp_we         = 1'b0;
    div_req.go     = 1'b0;
    div_req.hits   = hits_r;
    div_req.fill   = exp_fill_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          hdr_nxt      = in_header;
          op_nxt       = bhfs_pkg::op_t'(in_operation);
          idx_nxt      = '0;
          scan_len_nxt = (seen_count_r > fill_ext) ? seen_count_r : fill_ext;
          in_seen_nxt  = 1'b0;
          in_exp_nxt   = 1'b0;
          case (bhfs_pkg::op_t'(in_operation))
            bhfs_pkg::OP_CLEAR: begin
              seen_count_nxt = '0;
              hits_nxt       = '0;
            end
            bhfs_pkg::OP_OBSERVE: begin
              if (in_crc_ok &&
                  in_frame_len >= bhfs_pkg::LEN_W'(bhfs_pkg::MIN_FRAME_LEN)) begin
                state_nxt = S_SCAN;
              end
            end
            bhfs_pkg::OP_EXPECT: begin
              if (exp_fill_r < bhfs_pkg::FILL_W'(bhfs_pkg::EXP_DEPTH)) begin
                state_nxt = S_SCAN;
              end
            end
            bhfs_pkg::OP_FINISH: begin
              div_req.go = 1'b1;
              state_nxt  = S_DIV;
            end
            default: ;
          endcase
        end
      end

      // reads issue one entry a cycle; compares run in the cycle after each read, on the registered data
      S_SCAN: begin
        sv_nxt = issue && (idx_r < seen_count_r);
        ev_nxt = issue && (idx_r < fill_ext);
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (sv_r && (seen_q_r == hdr_r)) begin
          in_seen_nxt = 1'b1;
        end
        if (ev_r && (exp_q_r == hdr_r)) begin
          in_exp_nxt = 1'b1;
        end
        if (!issue && !sv_r && !ev_r) begin
          state_nxt = S_COMMIT;
        end
      end

      // a new header raises the hit count when it is already on the other side
      S_COMMIT: begin
        state_nxt = S_IDLE;
        if (op_r == bhfs_pkg::OP_OBSERVE) begin
          if (!in_seen_r && (seen_count_r < bhfs_pkg::CNT_W'(bhfs_pkg::FP_DEPTH))) begin
            seen_we        = 1'b1;
            seen_count_nxt = seen_count_r + 1'b1;
            if (in_exp_r) begin
              hits_nxt = hits_r + 1'b1;
            end
          end
        end else begin
          if (!in_exp_r && (exp_fill_r < bhfs_pkg::FILL_W'(bhfs_pkg::EXP_DEPTH))) begin
            exp_we       = 1'b1;
            exp_fill_nxt = exp_fill_r + 1'b1;
            if (in_seen_r) begin
              hits_nxt = hits_r + 1'b1;
            end
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          out_valid_nxt = 1'b1;
          out_conf_nxt  = div_rsp.quot;
          out_sel_nxt   = sel;
          out_tx_nxt    = sel && opt_in_r;
          out_seen_nxt  = seen_count_r;
          out_exp_nxt   = exp_fill_r;
          exp_fill_nxt  = '0;
          hits_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seen_count_r <= '0;
      exp_fill_r   <= '0;
      hits_r       <= '0;
      sv_r         <= 1'b0;
      ev_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      thresh_r     <= bhfs_pkg::PCT_W'(bhfs_pkg::THRESH_RESET);
      opt_in_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seen_count_r <= seen_count_nxt;
      exp_fill_r   <= exp_fill_nxt;
      hits_r       <= hits_nxt;
      sv_r         <= sv_nxt;
      ev_r         <= ev_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bhfs_pkg::CFG_THRESHOLD: thresh_r <= cfg_wdata;
          bhfs_pkg::CFG_OPT_IN:    opt_in_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    hdr_r      <= hdr_nxt;
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    scan_len_r <= scan_len_nxt;
    in_seen_r  <= in_seen_nxt;
    in_exp_r   <= in_exp_nxt;
    out_conf_r <= out_conf_nxt;
    out_sel_r  <= out_sel_nxt;
    out_tx_r   <= out_tx_nxt;
    out_seen_r <= out_seen_nxt;
    out_exp_r  <= out_exp_nxt;
  end

  // header set
  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_count_r[bhfs_pkg::FP_AW-1:0]] <= hdr_r;
    end
    if (sv_nxt) begin
      seen_q_r <= seen_mem[idx_r[bhfs_pkg::FP_AW-1:0]];
    end
  end

  // expected list
  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_mem[exp_fill_r[bhfs_pkg::EXP_AW-1:0]] <= hdr_r;
    end
    if (ev_nxt) begin
      exp_q_r <= exp_mem[idx_r[bhfs_pkg::EXP_AW-1:0]];
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_score_pct      = out_conf_r;
  assign out_selected       = out_sel_r;
  assign out_tx_allowed     = out_tx_r;
  assign out_distinct_seen  = out_seen_r;
  assign out_expected_count = out_exp_r;

  `ASSERT_NOW(a_hits_le_fill, 1'b1, hits_r <= exp_fill_r, "hit count exceeds expected fill")
  `ASSERT_NOW(a_seen_bound, 1'b1, seen_count_r <= bhfs_pkg::CNT_W'(bhfs_pkg::FP_DEPTH), "set overfull")
  `ASSERT_NEXT(a_result_clears, out_valid_nxt, (exp_fill_r == '0) && (hits_r == '0), "list not cleared")
  `ASSERT_NOW(a_write_after_scan, seen_we || exp_we, !sv_r && !ev_r && (state_r == S_COMMIT), "write during scan")
  `ASSERT_NOW(a_done_in_div, div_rsp.done, state_r == S_DIV, "divider result outside finish")

endmodule

// ----- tb/tb_bus_header_fingerprint_scorer_unit.sv -----
`timescale 1ns / 1ps

module tb_bus_header_fingerprint_scorer_unit;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 100;

  typedef struct packed {
    bhfs_pkg::op_t              op;
    logic [bhfs_pkg::HDR_W-1:0] hdr;
    logic                       crc;
    logic [bhfs_pkg::LEN_W-1:0] len;
  } frame_item_t;

  typedef struct packed {
    logic [bhfs_pkg::PCT_W-1:0]  pct;
    logic                        sel;
    logic                        tx;
    logic [bhfs_pkg::CNT_W-1:0]  seen;
    logic [bhfs_pkg::FILL_W-1:0] cnt;
  } score_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [bhfs_pkg::OP_W-1:0]       in_operation = bhfs_pkg::OP_CLEAR;
  logic [bhfs_pkg::HDR_W-1:0]      in_header = '0;
  logic                            in_crc_ok = 1'b0;
  logic [bhfs_pkg::LEN_W-1:0]      in_frame_len = '0;
  logic                            out_valid;
  logic [bhfs_pkg::PCT_W-1:0]      out_score_pct;
  logic                            out_selected;
  logic                            out_tx_allowed;
  logic [bhfs_pkg::CNT_W-1:0]      out_distinct_seen;
  logic [bhfs_pkg::FILL_W-1:0]     out_expected_count;
  logic                            cfg_we = 1'b0;
  logic [bhfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bhfs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  bus_header_fingerprint_scorer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_header          (in_header),
    .in_crc_ok          (in_crc_ok),
    .in_frame_len       (in_frame_len),
    .out_valid          (out_valid),
    .out_score_pct      (out_score_pct),
    .out_selected       (out_selected),
    .out_tx_allowed     (out_tx_allowed),
    .out_distinct_seen  (out_distinct_seen),
    .out_expected_count (out_expected_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  frame_item_t frame_queue[$];
  score_t      score_due[$];

  // scorer model state
  logic [bhfs_pkg::HDR_W-1:0] fp_set[bhfs_pkg::FP_DEPTH];
  int                         fp_fill = 0;
  logic [bhfs_pkg::HDR_W-1:0] prof_list[bhfs_pkg::EXP_DEPTH];
  int                         prof_fill = 0;
  logic [bhfs_pkg::PCT_W-1:0] thr_q = bhfs_pkg::PCT_W'(bhfs_pkg::THRESH_RESET);
  logic                       opt_q = 1'b0;

  int n_errors   = 0;
  int n_sent     = 0;
  int n_queued   = 0;
  int n_scores   = 0;
  int n_settings = 1;
  int cycles     = 0;
  int gap_left   = 0;
  int burst_left = 0;

  frame_item_t next_item;
  score_t      due;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic bit in_fp_set(input logic [bhfs_pkg::HDR_W-1:0] h);
    for (int i = 0; i < fp_fill; i++)
      if (fp_set[i] == h) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit in_prof_list(input logic [bhfs_pkg::HDR_W-1:0] h);
    for (int i = 0; i < prof_fill; i++)
      if (prof_list[i] == h) return 1'b1;
    return 1'b0;
  endfunction

  task automatic score_frame(input frame_item_t it);
    int     hits;
    int     pct;
    score_t s;
    case (it.op)
      bhfs_pkg::OP_CLEAR: begin
        fp_fill = 0;
      end
      bhfs_pkg::OP_OBSERVE: begin
        if (it.crc && it.len >= bhfs_pkg::MIN_FRAME_LEN && !in_fp_set(it.hdr) &&
            fp_fill < bhfs_pkg::FP_DEPTH) begin
          fp_set[fp_fill] = it.hdr;
          fp_fill++;
        end
      end
      bhfs_pkg::OP_EXPECT: begin
        if (prof_fill < bhfs_pkg::EXP_DEPTH && !in_prof_list(it.hdr)) begin
          prof_list[prof_fill] = it.hdr;
          prof_fill++;
        end
      end
      default: begin
        hits = 0;
        for (int i = 0; i < prof_fill; i++)
          if (in_fp_set(prof_list[i])) hits++;
        pct    = (prof_fill == 0) ? 0 : (hits * bhfs_pkg::PCT_SCALE) / prof_fill;
        s.pct  = pct[bhfs_pkg::PCT_W-1:0];
        s.sel  = (pct > 0) && (pct >= thr_q);
        s.tx   = s.sel && opt_q;
        s.seen = fp_fill[bhfs_pkg::CNT_W-1:0];
        s.cnt  = prof_fill[bhfs_pkg::FILL_W-1:0];
        score_due.push_back(s);
        prof_fill = 0;
      end
    endcase
  endtask

  function automatic frame_item_t item_of(input bhfs_pkg::op_t op,
                                          input logic [bhfs_pkg::HDR_W-1:0] h,
                                          input logic c,
                                          input logic [bhfs_pkg::LEN_W-1:0] l);
    frame_item_t it;
    it.op  = op;
    it.hdr = h;
    it.crc = c;
    it.len = l;
    return it;
  endfunction

  task automatic queue_item(input frame_item_t it);
    frame_queue.push_back(it);
    n_queued++;
  endtask

  // clear and finish carry junk in the fields they ignore
  task automatic queue_bare(input bhfs_pkg::op_t op);
    queue_item(item_of(op, bhfs_pkg::HDR_W'($urandom()), 1'($urandom_range(0, 1)),
                       bhfs_pkg::LEN_W'($urandom_range(0, 15))));
  endtask

  function automatic int idle_cycles();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one profile pass: maybe random items, maybe a clear, observed frames, expected headers, a finish
  task automatic gen_round();
    logic [bhfs_pkg::HDR_W-1:0] pool[$];
    logic [bhfs_pkg::HDR_W-1:0] h;
    logic                       c;
    logic [bhfs_pkg::LEN_W-1:0] l;
    int                         pool_n;
    int                         n_obs;
    int                         n_exp;
    bit                         big;
    big    = ($urandom_range(0, 7) == 0);
    pool_n = big ? $urandom_range(30, 40) : $urandom_range(1, 12);
    for (int i = 0; i < pool_n; i++) pool.push_back(bhfs_pkg::HDR_W'($urandom()));
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4))
        queue_item(item_of(bhfs_pkg::op_t'($urandom_range(0, 3)),
                           bhfs_pkg::HDR_W'($urandom()), 1'($urandom_range(0, 1)),
                           bhfs_pkg::LEN_W'($urandom_range(0, 15))));
    end
    if ($urandom_range(0, 3) == 0) queue_bare(bhfs_pkg::OP_CLEAR);
    n_obs = big ? pool_n + $urandom_range(0, 8) : $urandom_range(0, 12);
    for (int i = 0; i < n_obs; i++) begin
      if (big && i < pool_n) h = pool[i];
      else if ($urandom_range(0, 5) == 0) h = bhfs_pkg::HDR_W'($urandom());
      else h = pool[$urandom_range(0, pool_n - 1)];
      c = big ? 1'b1 : ($urandom_range(0, 7) != 0);
      l = ($urandom_range(0, 5) == 0 && !big) ? bhfs_pkg::LEN_W'($urandom_range(0, 2))
                                              : bhfs_pkg::LEN_W'($urandom_range(3, 15));
      queue_item(item_of(bhfs_pkg::OP_OBSERVE, h, c, l));
    end
    if (big) n_exp = $urandom_range(20, 40);
    else if ($urandom_range(0, 7) == 0) n_exp = $urandom_range(20, 30);
    else n_exp = $urandom_range(0, 10);
    for (int i = 0; i < n_exp; i++) begin
      if ($urandom_range(0, 4) == 0) h = bhfs_pkg::HDR_W'($urandom());
      else h = pool[$urandom_range(0, pool_n - 1)];
      queue_item(item_of(bhfs_pkg::OP_EXPECT, h, 1'($urandom_range(0, 1)),
                         bhfs_pkg::LEN_W'($urandom_range(0, 15))));
    end
    // a pass now and then runs on without a finish
    if ($urandom_range(0, 7) != 0) queue_bare(bhfs_pkg::OP_FINISH);
  endtask

  task automatic write_reg(input logic [bhfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bhfs_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bhfs_pkg::CFG_THRESHOLD) thr_q = val;
    else opt_q = val[0];
  endtask

  // sampled on the falling edge, clear of the driver's updates
  task automatic wait_idle();
    @(negedge clk);
    while (frame_queue.size() != 0 || start || busy || score_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver: holds start until the transfer, then an optional gap
  always @(posedge clk) begin
    if (!rst_n) begin
      start        <= 1'b0;
      in_operation <= bhfs_pkg::OP_CLEAR;
      in_header    <= '0;
      in_crc_ok    <= 1'b0;
      in_frame_len <= '0;
      gap_left = 0;
    end else if (!(start && busy)) begin
      if (start) gap_left = idle_cycles();
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (frame_queue.size() > 0) begin
        next_item = frame_queue.pop_front();
        in_operation <= next_item.op;
        in_header    <= next_item.hdr;
        in_crc_ok    <= next_item.crc;
        in_frame_len <= next_item.len;
        start        <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the result first, then predict from the transfer at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (score_due.size() == 0) begin
          flag_mismatch("result with no finish pending");
        end else begin
          due = score_due.pop_front();
          n_scores++;
          if (out_score_pct !== due.pct)
            flag_mismatch($sformatf("score_pct %0d, want %0d", out_score_pct, due.pct));
          if (out_selected !== due.sel)
            flag_mismatch($sformatf("selected %0b, want %0b", out_selected, due.sel));
          if (out_tx_allowed !== due.tx)
            flag_mismatch($sformatf("tx_allowed %0b, want %0b", out_tx_allowed, due.tx));
          if (out_distinct_seen !== due.seen)
            flag_mismatch($sformatf("distinct_seen %0d, want %0d", out_distinct_seen, due.seen));
          if (out_expected_count !== due.cnt)
            flag_mismatch($sformatf("expected_count %0d, want %0d",
                                    out_expected_count, due.cnt));
        end
      end
      if (start && !busy) begin
        score_frame(item_of(bhfs_pkg::op_t'(in_operation), in_header, in_crc_ok,
                            in_frame_len));
        n_sent++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int                         target;
    logic [bhfs_pkg::PCT_W-1:0] thr;
    logic                       opt;
    logic [5:0]                 pad;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, extremes, rejected frames, repeats, clear keeping the list
    queue_bare(bhfs_pkg::OP_FINISH);
    queue_item(item_of(bhfs_pkg::OP_OBSERVE, 24'h000000, 1'b1, 4'd3));
    queue_item(item_of(bhfs_pkg::OP_OBSERVE, 24'hFFFFFF, 1'b1, 4'd15));
    queue_item(item_of(bhfs_pkg::OP_OBSERVE, 24'hABCDEF, 1'b0, 4'd15));
    queue_item(item_of(bhfs_pkg::OP_OBSERVE, 24'h123456, 1'b1, 4'd2));
    queue_item(item_of(bhfs_pkg::OP_OBSERVE, 24'h654321, 1'b1, 4'd0));
    queue_item(item_of(bhfs_pkg::OP_OBSERVE, 24'hFFFFFF, 1'b1, 4'd7));
    queue_item(item_of(bhfs_pkg::OP_EXPECT, 24'h000000, 1'b0, 4'd0));
    queue_item(item_of(bhfs_pkg::OP_EXPECT, 24'hFFFFFF, 1'b1, 4'd15));
    queue_item(item_of(bhfs_pkg::OP_EXPECT, 24'hFFFFFF, 1'b0, 4'd9));
    queue_item(item_of(bhfs_pkg::OP_EXPECT, 24'hABCDEF, 1'b1, 4'd1));
    queue_item(item_of(bhfs_pkg::OP_EXPECT, 24'h123456, 1'b0, 4'd4));
    queue_bare(bhfs_pkg::OP_FINISH);
    queue_item(item_of(bhfs_pkg::OP_EXPECT, 24'h000000, 1'b1, 4'd3));
    queue_item(item_of(bhfs_pkg::OP_EXPECT, 24'h5A5A5A, 1'b0, 4'd8));
    queue_item(item_of(bhfs_pkg::OP_EXPECT, 24'hA5A5A5, 1'b1, 4'd12));
    queue_bare(bhfs_pkg::OP_FINISH);
    queue_item(item_of(bhfs_pkg::OP_EXPECT, 24'h000000, 1'b0, 4'd15));
    queue_bare(bhfs_pkg::OP_CLEAR);
    queue_item(item_of(bhfs_pkg::OP_OBSERVE, 24'h000000, 1'b1, 4'd3));
    queue_bare(bhfs_pkg::OP_FINISH);
    queue_bare(bhfs_pkg::OP_CLEAR);
    queue_bare(bhfs_pkg::OP_FINISH);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: begin thr = 7'd0;   opt = 1'b1; end
          2: begin thr = 7'd100; opt = 1'b1; end
          3: begin thr = 7'd127; opt = 1'b1; end
          4: begin thr = 7'd1;   opt = 1'b0; end
          5: begin thr = bhfs_pkg::PCT_W'($urandom_range(0, 100)); opt = 1'b1; end
          default: begin
            thr = bhfs_pkg::PCT_W'($urandom_range(0, 127));
            opt = 1'($urandom_range(0, 1));
          end
        endcase
        pad = 6'($urandom_range(0, 63));
        wait_idle();
        write_reg(bhfs_pkg::CFG_THRESHOLD, thr);
        write_reg(bhfs_pkg::CFG_OPT_IN, {pad, opt});
        n_settings++;
        @(negedge clk);
      end
      target = n_queued + PHASE_ITEMS;
      while (n_queued < target) gen_round();
    end
    wait_idle();

    $display("%0d frames transferred, %0d scores checked under %0d register settings",
             n_sent, n_scores, n_settings);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
